FILE: hw/rtl/dtfu_pkg.sv
// Shared types, constants and lookup functions for the degree trig function unit.
// Used by the square-root, rotation and divider step modules and by the top level.
package dtfu_pkg;

  localparam int CORDIC_STAGES_DEF = 20;
  localparam int SQRT_STEPS = 17;
  localparam int DIV_STEPS = 34;
  localparam int CW = 49;

  localparam logic [1:0] FN_SIN = 2'd0;
  localparam logic [1:0] FN_COS = 2'd1;
  localparam logic [1:0] FN_TAN = 2'd2;

  localparam logic CFG_FUNCTION = 1'b0;
  localparam logic CFG_INVERSE = 1'b1;

  localparam logic [31:0] RECIP45 = 32'd3054198967;
  localparam logic signed [CW-1:0] GAIN = CW'(652032874);
  localparam logic signed [CW-1:0] UNIT_VEC = CW'(1073741824);

  localparam logic signed [31:0] NINETY_IN = 32'sd5898240;
  localparam logic signed [31:0] NEG_NINETY_IN = -32'sd5898240;
  localparam logic signed [31:0] ONE_IN = 32'sd65536;
  localparam logic signed [31:0] NEG_ONE_IN = -32'sd65536;

  localparam logic signed [33:0] SAT_RES = 34'sd6553534464;
  localparam logic signed [33:0] NEG_SAT_RES = -34'sd6553534464;
  localparam logic signed [33:0] NINETY_RES = 34'sd5898240;
  localparam logic signed [33:0] NEG_NINETY_RES = -34'sd5898240;
  localparam logic signed [33:0] ONE_EIGHTY_RES = 34'sd11796480;

  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_ACOS,
    KIND_TAN
  } kind_t;

  typedef struct packed {
    logic              valid;
    logic signed [31:0] v;
    logic [1:0]        fn;
    logic              inv;
    logic signed [31:0] ang;
    logic              neg;
  } sq_side_t;

  typedef struct packed {
    logic              valid;
    logic signed [31:0] v;
    logic [1:0]        fn;
    logic              inv;
    logic              neg;
    logic              vec;
  } cor_side_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic signed [33:0] pre;
    logic              tsign;
    logic              ovf;
  } div_side_t;

  function automatic logic [31:0] atan_bam(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'd536870912;
      1: r = 32'd316933406;
      2: r = 32'd167458907;
      3: r = 32'd85004756;
      4: r = 32'd42667331;
      5: r = 32'd21354465;
      6: r = 32'd10679838;
      7: r = 32'd5340245;
      8: r = 32'd2670163;
      9: r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Rounded binary-angle contribution of a degree remainder below 45.
  function automatic logic [12:0] deg_frac_bam(input logic [5:0] r);
    logic [12:0] f;
    case (r)
      6'd0: f = 13'd0;       6'd1: f = 13'd182;     6'd2: f = 13'd364;
      6'd3: f = 13'd546;     6'd4: f = 13'd728;     6'd5: f = 13'd910;
      6'd6: f = 13'd1092;    6'd7: f = 13'd1274;    6'd8: f = 13'd1456;
      6'd9: f = 13'd1638;    6'd10: f = 13'd1820;   6'd11: f = 13'd2002;
      6'd12: f = 13'd2185;   6'd13: f = 13'd2367;   6'd14: f = 13'd2549;
      6'd15: f = 13'd2731;   6'd16: f = 13'd2913;   6'd17: f = 13'd3095;
      6'd18: f = 13'd3277;   6'd19: f = 13'd3459;   6'd20: f = 13'd3641;
      6'd21: f = 13'd3823;   6'd22: f = 13'd4005;   6'd23: f = 13'd4187;
      6'd24: f = 13'd4369;   6'd25: f = 13'd4551;   6'd26: f = 13'd4733;
      6'd27: f = 13'd4915;   6'd28: f = 13'd5097;   6'd29: f = 13'd5279;
      6'd30: f = 13'd5461;   6'd31: f = 13'd5643;   6'd32: f = 13'd5825;
      6'd33: f = 13'd6007;   6'd34: f = 13'd6190;   6'd35: f = 13'd6372;
      6'd36: f = 13'd6554;   6'd37: f = 13'd6736;   6'd38: f = 13'd6918;
      6'd39: f = 13'd7100;   6'd40: f = 13'd7282;   6'd41: f = 13'd7464;
      6'd42: f = 13'd7646;   6'd43: f = 13'd7828;   6'd44: f = 13'd8010;
      default: f = 13'd0;
    endcase
    return f;
  endfunction

endpackage

FILE: hw/rtl/dtfu_sqrt_cell.sv
// One step of the pipelined integer square root, producing one result bit.
// Depends on dtfu_pkg for the side payload type.
module dtfu_sqrt_cell #(
  parameter int K = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  dtfu_pkg::sq_side_t side_i,
  input  logic [33:0]       rem_i,
  input  logic [33:0]       root_i,
  output dtfu_pkg::sq_side_t side_o,
  output logic [33:0]       rem_o,
  output logic [33:0]       root_o
);

  localparam logic [33:0] BIT = 34'd1 << (2 * K);

  logic [33:0] trial;
  logic        fits;

  assign trial = root_i + BIT;
  assign fits = rem_i >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_o <= '0;
    end else begin
      side_o <= side_i;
    end
    if (fits) begin
      rem_o <= rem_i - trial;
      root_o <= (root_i >> 1) + BIT;
    end else begin
      rem_o <= rem_i;
      root_o <= root_i >> 1;
    end
  end

endmodule

FILE: hw/rtl/dtfu_cordic_cell.sv
// One CORDIC micro-rotation, shared by rotation and vectoring modes.
// Depends on dtfu_pkg for the arctangent table and the side payload type.
module dtfu_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dtfu_pkg::cor_side_t         side_i,
  input  logic signed [dtfu_pkg::CW-1:0] x_i,
  input  logic signed [dtfu_pkg::CW-1:0] y_i,
  input  logic signed [31:0]          z_i,
  output dtfu_pkg::cor_side_t         side_o,
  output logic signed [dtfu_pkg::CW-1:0] x_o,
  output logic signed [dtfu_pkg::CW-1:0] y_o,
  output logic signed [31:0]          z_o
);

  localparam logic signed [31:0] ANG = dtfu_pkg::atan_bam(STAGE);

  logic signed [dtfu_pkg::CW-1:0] xs;
  logic signed [dtfu_pkg::CW-1:0] ys;
  logic                           pos;

  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;
  assign pos = side_i.vec ? y_i[dtfu_pkg::CW-1] : ~z_i[31];

  always_ff @(posedge clk) begin
    if (rst) begin
      side_o <= '0;
    end else begin
      side_o <= side_i;
    end
    if (pos) begin
      x_o <= x_i - ys;
      y_o <= y_i + xs;
      z_o <= z_i - ANG;
    end else begin
      x_o <= x_i + ys;
      y_o <= y_i - xs;
      z_o <= z_i + ANG;
    end
  end

endmodule

FILE: hw/rtl/dtfu_div_cell.sv
// One restoring-division step that yields one quotient bit.
// Depends on dtfu_pkg for the side payload type.
module dtfu_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  dtfu_pkg::div_side_t side_i,
  input  logic [32:0]        d_i,
  input  logic [33:0]        rem_i,
  input  logic [33:0]        nq_i,
  output dtfu_pkg::div_side_t side_o,
  output logic [32:0]        d_o,
  output logic [33:0]        rem_o,
  output logic [33:0]        nq_o
);

  logic [33:0] trial;
  logic        fits;

  assign trial = {rem_i[32:0], nq_i[33]};
  assign fits = trial >= {1'b0, d_i};

  always_ff @(posedge clk) begin
    if (rst) begin
      side_o <= '0;
    end else begin
      side_o <= side_i;
    end
    d_o <= d_i;
    rem_o <= fits ? trial - {1'b0, d_i} : trial;
    nq_o <= {nq_i[32:0], fits};
  end

endmodule

FILE: hw/rtl/degree_trig_function_unit.sv
// Fully pipelined unit that takes one word per clock while busy is low and returns one
// result word per word, in order; the depth is set by the integer square root, the CORDIC
// rotation chain and the tangent divider, which every word passes through. busy is high
// while reset is applied and for the first cycle after it, and done marks each result for
// one cycle with no way to hold it back.
// Depends on dtfu_pkg, dtfu_sqrt_cell, dtfu_cordic_cell and dtfu_div_cell.
module degree_trig_function_unit #(
  parameter int CORDIC_STAGES = dtfu_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] operand_value,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_data,
  output logic               done,
  output logic signed [33:0] result_value
);

  localparam int SQ = dtfu_pkg::SQRT_STEPS;
  localparam int DV = dtfu_pkg::DIV_STEPS;
  localparam int CW = dtfu_pkg::CW;
  localparam logic signed [32:0] QTR = 33'sh040000000;
  localparam logic signed [32:0] HALF = 33'sh080000000;
  localparam logic signed [32:0] NEG_QTR = -33'sh040000000;

  logic [1:0] function_select;
  logic       inverse_mode;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      function_select <= 2'd0;
      inverse_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        dtfu_pkg::CFG_FUNCTION: function_select <= cfg_data;
        dtfu_pkg::CFG_INVERSE: inverse_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start & ~busy;

  logic               s1_valid, s2_valid, s3_valid, s4_valid;
  logic signed [31:0] s1_v, s2_v, s3_v, s4_v;
  logic [1:0]         s1_fn, s2_fn, s3_fn, s4_fn;
  logic               s1_inv, s2_inv, s3_inv, s4_inv;
  logic [31:0]        u1, s2_u, s3_u;
  logic [63:0]        prod1, s2_prod;
  logic [33:0]        sq1, s2_sq;
  logic [26:0]        s3_qu, s4_qu;
  logic [32:0]        s3_t, s4_t;
  logic [31:0]        qm4, ru4;
  logic [5:0]         s4_ru;

  assign u1 = s1_v[31] ? 32'(-s1_v) : 32'(s1_v);
  assign prod1 = u1 * dtfu_pkg::RECIP45;
  assign sq1 = u1[16:0] * u1[16:0];
  assign qm4 = 32'(s3_qu) * 32'd45;
  assign ru4 = s3_u - qm4;

  always_ff @(posedge clk) begin
    s1_v <= operand_value;
    s1_fn <= function_select;
    s1_inv <= inverse_mode;
    s2_v <= s1_v;
    s2_fn <= s1_fn;
    s2_inv <= s1_inv;
    s2_u <= u1;
    s2_prod <= prod1;
    s2_sq <= sq1;
    s3_v <= s2_v;
    s3_fn <= s2_fn;
    s3_inv <= s2_inv;
    s3_u <= s2_u;
    s3_qu <= s2_prod[63:37];
    s3_t <= 33'h100000000 - s2_sq[32:0];
    s4_v <= s3_v;
    s4_fn <= s3_fn;
    s4_inv <= s3_inv;
    s4_qu <= s3_qu;
    s4_ru <= ru4[5:0];
    s4_t <= s3_t;
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Degrees to binary angle, then fold into the right half plane.
  logic [39:0]        q5, b5;
  logic signed [32:0] a5w, f5;
  logic               neg5;

  assign q5 = {s4_qu, dtfu_pkg::deg_frac_bam(s4_ru)};
  assign b5 = s4_v[31] ? -q5 : q5;
  assign a5w = {b5[31], b5[31:0]};

  always_comb begin
    f5 = a5w;
    neg5 = 1'b0;
    if (a5w > QTR) begin
      f5 = a5w - HALF;
      neg5 = 1'b1;
    end else if (a5w < NEG_QTR) begin
      f5 = a5w + HALF;
      neg5 = 1'b1;
    end
  end

  dtfu_pkg::sq_side_t sq_side [SQ+1];
  logic [33:0]        sq_rem [SQ+1];
  logic [33:0]        sq_root [SQ+1];

  always_ff @(posedge clk) begin
    sq_side[0].v <= s4_v;
    sq_side[0].fn <= s4_fn;
    sq_side[0].inv <= s4_inv;
    sq_side[0].ang <= f5[31:0];
    sq_side[0].neg <= neg5;
    sq_rem[0] <= {1'b0, s4_t};
    sq_root[0] <= 34'd0;
    if (rst) begin
      sq_side[0].valid <= 1'b0;
    end else begin
      sq_side[0].valid <= s4_valid;
    end
  end

  genvar j;
  for (j = 0; j < SQ; j++) begin : g_sqrt
    dtfu_sqrt_cell #(.K(SQ - 1 - j)) u_step (
      .clk    (clk),
      .rst    (rst),
      .side_i (sq_side[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .side_o (sq_side[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1])
    );
  end

  // Starting vector for the rotation chain.
  dtfu_pkg::cor_side_t cor_side [CORDIC_STAGES+1];
  logic signed [CW-1:0] cor_x [CORDIC_STAGES+1];
  logic signed [CW-1:0] cor_y [CORDIC_STAGES+1];
  logic signed [31:0]   cor_z [CORDIC_STAGES+1];
  logic signed [CW-1:0] vext, x0, y0;
  logic signed [31:0]   z0;

  assign vext = CW'(sq_side[SQ].v);

  always_comb begin
    if (!sq_side[SQ].inv) begin
      x0 = dtfu_pkg::GAIN;
      y0 = '0;
      z0 = sq_side[SQ].ang;
    end else if (sq_side[SQ].fn == dtfu_pkg::FN_TAN) begin
      x0 = dtfu_pkg::UNIT_VEC;
      y0 = vext <<< 14;
      z0 = '0;
    end else begin
      x0 = CW'({sq_root[SQ][16:0], 14'd0});
      y0 = vext <<< 14;
      z0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    cor_side[0].v <= sq_side[SQ].v;
    cor_side[0].fn <= sq_side[SQ].fn;
    cor_side[0].inv <= sq_side[SQ].inv;
    cor_side[0].neg <= sq_side[SQ].neg;
    cor_side[0].vec <= sq_side[SQ].inv;
    cor_x[0] <= x0;
    cor_y[0] <= y0;
    cor_z[0] <= z0;
    if (rst) begin
      cor_side[0].valid <= 1'b0;
    end else begin
      cor_side[0].valid <= sq_side[SQ].valid;
    end
  end

  genvar i;
  for (i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    dtfu_cordic_cell #(.STAGE(i)) u_step (
      .clk    (clk),
      .rst    (rst),
      .side_i (cor_side[i]),
      .x_i    (cor_x[i]),
      .y_i    (cor_y[i]),
      .z_i    (cor_z[i]),
      .side_o (cor_side[i+1]),
      .x_o    (cor_x[i+1]),
      .y_o    (cor_y[i+1]),
      .z_o    (cor_z[i+1])
    );
  end

  // Scale the vector or angle, and set up the tangent division.
  dtfu_pkg::cor_side_t  cs;
  logic signed [CW-1:0] px, py, pz_s, smag;
  logic signed [31:0]   pz;
  logic [CW-1:0]        rmag;
  logic signed [33:0]   sc;
  logic [CW-1:0]        ym;
  logic [48:0]          num;
  logic [32:0]          dvs;
  logic                 ovf;
  logic [31:0]          zm;
  logic [37:0]          pdeg;
  logic signed [33:0]   deg;
  logic                 xnp;
  dtfu_pkg::div_side_t  nside;

  assign cs = cor_side[CORDIC_STAGES];
  assign px = cor_x[CORDIC_STAGES];
  assign py = cor_y[CORDIC_STAGES];
  assign pz = cor_z[CORDIC_STAGES];
  assign pz_s = (cs.fn == dtfu_pkg::FN_SIN) ? py : px;
  assign smag = pz_s[CW-1] ? -pz_s : pz_s;
  assign rmag = (CW'(smag) + CW'(8192)) >> 14;
  assign sc = (pz_s[CW-1] ^ cs.neg) ? -34'(rmag) : 34'(rmag);
  assign ym = py[CW-1] ? CW'(-py) : CW'(py);
  assign num = {1'b0, ym[31:0], 16'd0} + 49'(px[32:1]);
  assign dvs = px[32:0];
  assign ovf = 33'(num[48:34]) >= dvs;
  assign zm = pz[31] ? 32'(-pz) : 32'(pz);
  assign pdeg = 38'(zm) * 38'd45 + 38'd4096;
  assign deg = pz[31] ? -34'(pdeg[37:13]) : 34'(pdeg[37:13]);
  assign xnp = px[CW-1] | (px == '0);

  always_comb begin
    nside.valid = cs.valid;
    nside.kind = dtfu_pkg::KIND_DIRECT;
    nside.pre = '0;
    nside.tsign = py[CW-1];
    nside.ovf = ovf;
    if (cs.fn > dtfu_pkg::FN_TAN) begin
      nside.pre = '0;
    end else if (!cs.inv) begin
      if (cs.fn == dtfu_pkg::FN_TAN) begin
        if (cs.v > dtfu_pkg::NINETY_IN) begin
          nside.pre = dtfu_pkg::SAT_RES;
        end else if (cs.v < dtfu_pkg::NEG_NINETY_IN) begin
          nside.pre = dtfu_pkg::NEG_SAT_RES;
        end else if (xnp) begin
          nside.pre = cs.v[31] ? dtfu_pkg::NEG_SAT_RES : dtfu_pkg::SAT_RES;
        end else begin
          nside.kind = dtfu_pkg::KIND_TAN;
        end
      end else begin
        nside.pre = sc;
      end
    end else if (cs.fn == dtfu_pkg::FN_SIN) begin
      if (cs.v >= dtfu_pkg::ONE_IN) begin
        nside.pre = dtfu_pkg::NINETY_RES;
      end else if (cs.v <= dtfu_pkg::NEG_ONE_IN) begin
        nside.pre = dtfu_pkg::NEG_NINETY_RES;
      end else begin
        nside.pre = deg;
      end
    end else if (cs.fn == dtfu_pkg::FN_COS) begin
      if (cs.v >= dtfu_pkg::ONE_IN) begin
        nside.pre = '0;
      end else if (cs.v <= dtfu_pkg::NEG_ONE_IN) begin
        nside.pre = dtfu_pkg::ONE_EIGHTY_RES;
      end else begin
        nside.pre = deg;
        nside.kind = dtfu_pkg::KIND_ACOS;
      end
    end else begin
      nside.pre = deg;
    end
  end

  dtfu_pkg::div_side_t dv_side [DV+1];
  logic [32:0]         dv_d [DV+1];
  logic [33:0]         dv_rem [DV+1];
  logic [33:0]         dv_nq [DV+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_side[0] <= '0;
    end else begin
      dv_side[0] <= nside;
    end
    dv_d[0] <= dvs;
    dv_rem[0] <= 34'(num[48:34]);
    dv_nq[0] <= num[33:0];
  end

  genvar k;
  for (k = 0; k < DV; k++) begin : g_div
    dtfu_div_cell u_step (
      .clk    (clk),
      .rst    (rst),
      .side_i (dv_side[k]),
      .d_i    (dv_d[k]),
      .rem_i  (dv_rem[k]),
      .nq_i   (dv_nq[k]),
      .side_o (dv_side[k+1]),
      .d_o    (dv_d[k+1]),
      .rem_o  (dv_rem[k+1]),
      .nq_o   (dv_nq[k+1])
    );
  end

  // Final selection: saturated tangent, arccosine from arcsine, or passed value.
  logic [33:0]        qc;
  logic signed [33:0] res;

  assign qc = (dv_side[DV].ovf || dv_nq[DV] > 34'(dtfu_pkg::SAT_RES)) ?
              34'(dtfu_pkg::SAT_RES) : dv_nq[DV];

  always_comb begin
    case (dv_side[DV].kind)
      dtfu_pkg::KIND_TAN: res = dv_side[DV].tsign ? -signed'(qc) : signed'(qc);
      dtfu_pkg::KIND_ACOS: res = dtfu_pkg::NINETY_RES - dv_side[DV].pre;
      default: res = dv_side[DV].pre;
    endcase
  end

  always_ff @(posedge clk) begin
    result_value <= res;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_side[DV].valid;
    end
  end

endmodule
